// ===== rtl/cdv_pkg.sv =====
// Shared types and constants for the contour disc volume block.
package cdv_pkg;

  localparam int COORD_W = 10;
  localparam int SCALE_W = 32;
  localparam int HALF_W  = 16;
  localparam int VOL_W   = 56;
  localparam int IN_DATA_W = 24;

  // One column of the store: seen flag plus row extent.
  typedef struct packed {
    logic               seen;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] bottom;
  } col_entry_t;

  typedef struct packed {
    logic pt;    // merge a point into its column
    logic walk;  // read a column for the walk and clear it
  } store_op_t;

  typedef struct packed {
    logic clear_busy;
    logic walk_busy;
  } store_stat_t;

  typedef struct packed {
    logic clr;     // start a new sum
    logic mul_lo;  // sum times low half of scale
    logic mul_hi;  // sum times high half of scale
    logic add;     // combine partial products
  } calc_ctrl_t;

endpackage

// ===== rtl/cdv_column_store.sv =====
// Column extent memory with read-modify-write, forwarding and clear sweep.
module cdv_column_store #(
  parameter int IMAGE_WIDTH = 1024,
  parameter int COL_W       = 10
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cdv_pkg::store_op_t          op,
  input  logic [COL_W-1:0]            op_addr,
  input  logic [cdv_pkg::COORD_W-1:0] op_y,
  output cdv_pkg::store_stat_t        stat,
  output logic                        walk_vld,
  output cdv_pkg::col_entry_t         walk_entry
);

  cdv_pkg::col_entry_t mem [IMAGE_WIDTH];
  cdv_pkg::col_entry_t rd_data_r;

  cdv_pkg::store_op_t          s1_op_r;
  logic [COL_W-1:0]            s1_addr_r;
  logic [cdv_pkg::COORD_W-1:0] s1_y_r;

  logic                fwd_vld_r;
  logic [COL_W-1:0]    fwd_addr_r;
  cdv_pkg::col_entry_t fwd_data_r;

  logic             clr_busy_r;
  logic [COL_W-1:0] clr_cnt_r;

  cdv_pkg::col_entry_t cur;
  cdv_pkg::col_entry_t upd;
  logic                wr_en;
  logic [COL_W-1:0]    wr_addr;
  cdv_pkg::col_entry_t wr_data;

  // the previous write is not yet visible to a read issued at the same edge
  assign cur = (fwd_vld_r && fwd_addr_r == s1_addr_r) ? fwd_data_r : rd_data_r;

  always_comb begin
    upd.seen = 1'b1;
    if (cur.seen) begin
      upd.top    = (s1_y_r < cur.top)    ? s1_y_r : cur.top;
      upd.bottom = (s1_y_r > cur.bottom) ? s1_y_r : cur.bottom;
    end else begin
      upd.top    = s1_y_r;
      upd.bottom = s1_y_r;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = s1_addr_r;
    wr_data = '0;
    if (clr_busy_r) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_r;
    end else if (s1_op_r.pt) begin
      wr_en   = 1'b1;
      wr_data = upd;
    end else if (s1_op_r.walk) begin
      wr_en   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[op_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_op_r    <= '0;
      fwd_vld_r  <= 1'b0;
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else begin
      s1_op_r   <= op;
      fwd_vld_r <= wr_en;
      if (clr_busy_r) begin
        if (clr_cnt_r == COL_W'(IMAGE_WIDTH - 1)) begin
          clr_busy_r <= 1'b0;
        end
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_addr_r  <= op_addr;
    s1_y_r     <= op_y;
    fwd_addr_r <= wr_addr;
    fwd_data_r <= wr_data;
  end

  assign stat.clear_busy = clr_busy_r;
  assign stat.walk_busy  = s1_op_r.walk;
  assign walk_vld        = s1_op_r.walk;
  assign walk_entry      = cur;

endmodule

// ===== rtl/cdv_volume_calc.sv =====
// Diameter clamp, sum of squares, split scale multiply and saturation.
module cdv_volume_calc #(
  parameter int IMAGE_WIDTH    = 1024,
  parameter int DIAMETER_LIMIT = 100
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cdv_pkg::calc_ctrl_t         ctrl,
  input  logic [cdv_pkg::SCALE_W-1:0] scale,
  input  logic                        walk_vld,
  input  cdv_pkg::col_entry_t         walk_entry,
  output logic                        busy,
  output logic [cdv_pkg::VOL_W-1:0]   volume,
  output logic                        overflow
);

  localparam int DIAM_W = (DIAMETER_LIMIT > 2) ? $clog2(DIAMETER_LIMIT) : 1;
  localparam longint unsigned SUM_MAX =
    longint'(IMAGE_WIDTH) * longint'(DIAMETER_LIMIT - 1) * longint'(DIAMETER_LIMIT - 1);
  localparam int SUM_W  = $clog2(SUM_MAX + 1);
  localparam int PROD_W = SUM_W + cdv_pkg::HALF_W;
  localparam int ACC_W  = (SUM_W + cdv_pkg::SCALE_W > cdv_pkg::VOL_W + 1) ?
                          SUM_W + cdv_pkg::SCALE_W : cdv_pkg::VOL_W + 1;
  localparam int SPAN_W = cdv_pkg::COORD_W + 1;

  logic [SPAN_W-1:0] span;
  logic [SPAN_W-1:0] dia_raw;
  logic              dia_ok;
  logic              dia_big;

  logic              dia_vld_r;
  logic [DIAM_W-1:0] dia_r;
  logic              dia_ovf_r;

  logic [SUM_W-1:0]    sum_r;
  logic                ovf_r;
  logic [2*DIAM_W-1:0] sq;

  logic [cdv_pkg::HALF_W-1:0] mul_b;
  logic [PROD_W-1:0]          prod;
  logic [PROD_W-1:0]          p_lo_r;
  logic [PROD_W-1:0]          p_hi_r;
  logic [ACC_W-1:0]           full_r;

  assign span    = SPAN_W'(walk_entry.bottom) - SPAN_W'(walk_entry.top);
  // diameter is bottom - top - 1; only one or more counts
  assign dia_ok  = walk_entry.seen && !span[SPAN_W-1] && span >= SPAN_W'(2);
  assign dia_raw = span - SPAN_W'(1);
  assign dia_big = dia_raw >= SPAN_W'(DIAMETER_LIMIT);

  assign sq = dia_r * dia_r;

  assign mul_b = ctrl.mul_hi ? scale[cdv_pkg::SCALE_W-1:cdv_pkg::HALF_W]
                             : scale[cdv_pkg::HALF_W-1:0];
  assign prod  = PROD_W'(sum_r) * PROD_W'(mul_b);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dia_vld_r <= 1'b0;
      dia_ovf_r <= 1'b0;
      sum_r     <= '0;
      ovf_r     <= 1'b0;
    end else begin
      dia_vld_r <= walk_vld;
      dia_ovf_r <= walk_vld && dia_ok && dia_big;
      if (ctrl.clr) begin
        sum_r <= '0;
        ovf_r <= 1'b0;
      end else if (dia_vld_r) begin
        sum_r <= sum_r + SUM_W'(sq);
        ovf_r <= ovf_r | dia_ovf_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!dia_ok) begin
      dia_r <= '0;
    end else if (dia_big) begin
      dia_r <= DIAM_W'(DIAMETER_LIMIT - 1);
    end else begin
      dia_r <= DIAM_W'(dia_raw);
    end
    if (ctrl.mul_lo) begin
      p_lo_r <= prod;
    end
    if (ctrl.mul_hi) begin
      p_hi_r <= prod;
    end
    if (ctrl.add) begin
      full_r <= (ACC_W'(p_hi_r) << cdv_pkg::HALF_W) + ACC_W'(p_lo_r);
    end
  end

  assign busy     = dia_vld_r;
  assign volume   = (|full_r[ACC_W-1:cdv_pkg::VOL_W]) ? '1 : full_r[cdv_pkg::VOL_W-1:0];
  assign overflow = ovf_r;

endmodule

// ===== rtl/contour_disc_volume_core.sv =====
// Top level: contour point intake, column walk control and result register.
//
//  channel  dir  handshake            payload
//  in_      in   in_tvalid/in_tready  in_tdata: point_x [9:0], point_y [19:10]; in_tlast
//  out_     out  out_tvalid/out_tready out_tdata: volume [55:0]; out_tuser: diameter_overflow
//  cfg_     in   cfg_wr_en            cfg_wr_data: volume_scale [31:0]
//
// Points are taken one per cycle while the block is collecting; each is merged into its column entry by a
// read-modify-write on the column memory, with the previous write forwarded.
// The last point starts a walk of one cycle per column from the leftmost to the
// rightmost column seen, then a drain, the split multiply, the add and the result
// load. After reset a clearing pass over all IMAGE_WIDTH columns runs before the
// first point is taken. A stalled result holds the block before its next frame.
module contour_disc_volume_core #(
  parameter int IMAGE_WIDTH    = 1024,
  parameter int IMAGE_HEIGHT   = 1024,
  parameter int DIAMETER_LIMIT = 100
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [cdv_pkg::IN_DATA_W-1:0] in_tdata,   // point_x, point_y
  input  logic                          in_tlast,   // last_point
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [cdv_pkg::VOL_W-1:0]     out_tdata,  // volume
  output logic                          out_tuser,  // diameter_overflow
  input  logic                          cfg_wr_en,
  input  logic [cdv_pkg::SCALE_W-1:0]   cfg_wr_data // volume_scale
);

  localparam int COL_W = (IMAGE_WIDTH > 2) ? $clog2(IMAGE_WIDTH) : 1;
  localparam logic [cdv_pkg::SCALE_W-1:0] SCALE_RESET = 32'h0001_0000;

  typedef enum logic [7:0] {
    S_CLEAR   = 8'b0000_0001,
    S_COLLECT = 8'b0000_0010,
    S_WALK    = 8'b0000_0100,
    S_FLUSH   = 8'b0000_1000,
    S_MUL_LO  = 8'b0001_0000,
    S_MUL_HI  = 8'b0010_0000,
    S_ADD     = 8'b0100_0000,
    S_OUT     = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [cdv_pkg::SCALE_W-1:0] scale_r;
  logic [COL_W-1:0] left_r, left_nxt;
  logic [COL_W-1:0] right_r, right_nxt;
  logic             any_r, any_nxt;
  logic [COL_W-1:0] col_r, col_nxt;

  logic                    out_vld_r;
  logic [cdv_pkg::VOL_W-1:0] out_vol_r;
  logic                    out_ovf_r;

  logic [cdv_pkg::COORD_W-1:0] pt_x;
  logic [cdv_pkg::COORD_W-1:0] pt_y;
  logic [COL_W-1:0]            pt_col;
  logic                        in_xfer;
  logic                        pt_in_range;
  logic                        out_load;

  cdv_pkg::store_op_t   op;
  logic [COL_W-1:0]     op_addr;
  cdv_pkg::store_stat_t stat;
  logic                 walk_vld;
  cdv_pkg::col_entry_t  walk_entry;
  cdv_pkg::calc_ctrl_t  ctrl;
  logic                 calc_busy;
  logic [cdv_pkg::VOL_W-1:0] volume;
  logic                 overflow;

  assign pt_x   = in_tdata[cdv_pkg::COORD_W-1:0];
  assign pt_y   = in_tdata[2*cdv_pkg::COORD_W-1:cdv_pkg::COORD_W];
  assign pt_col = COL_W'(pt_x);

  assign in_tready   = (state_r == S_COLLECT);
  assign in_xfer     = in_tvalid && in_tready;
  assign pt_in_range = (32'(pt_x) < 32'(IMAGE_WIDTH)) && (32'(pt_y) < 32'(IMAGE_HEIGHT));

  assign op.pt   = in_xfer && pt_in_range;
  assign op.walk = (state_r == S_WALK);
  assign op_addr = op.walk ? col_r : pt_col;

  assign out_load = (state_r == S_OUT) && (!out_vld_r || out_tready);

  assign ctrl.clr    = in_xfer && in_tlast;
  assign ctrl.mul_lo = (state_r == S_MUL_LO);
  assign ctrl.mul_hi = (state_r == S_MUL_HI);
  assign ctrl.add    = (state_r == S_ADD);

  // extents, updated by every in-range point and reset when the walk reaches the rightmost column
  always_comb begin
    left_nxt  = left_r;
    right_nxt = right_r;
    any_nxt   = any_r;
    if (op.pt) begin
      any_nxt = 1'b1;
      if (!any_r) begin
        left_nxt  = pt_col;
        right_nxt = pt_col;
      end else begin
        if (pt_col < left_r) left_nxt = pt_col;
        if (pt_col > right_r) right_nxt = pt_col;
      end
    end
    if (state_r == S_WALK && col_r == right_r) begin
      left_nxt  = '0;
      right_nxt = '0;
      any_nxt   = 1'b0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    col_nxt   = col_r;
    case (state_r)
      S_CLEAR: begin
        if (!stat.clear_busy) state_nxt = S_COLLECT;
      end
      S_COLLECT: begin
        if (in_xfer && in_tlast) begin
          state_nxt = S_WALK;
          col_nxt   = left_nxt;
        end
      end
      S_WALK: begin
        if (col_r == right_r) begin
          state_nxt = S_FLUSH;
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
      S_FLUSH: begin
        if (!stat.walk_busy && !calc_busy) state_nxt = S_MUL_LO;
      end
      S_MUL_LO: state_nxt = S_MUL_HI;
      S_MUL_HI: state_nxt = S_ADD;
      S_ADD:    state_nxt = S_OUT;
      S_OUT: begin
        if (out_load) state_nxt = S_COLLECT;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      scale_r   <= SCALE_RESET;
      left_r    <= '0;
      right_r   <= '0;
      any_r     <= 1'b0;
      col_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      left_r  <= left_nxt;
      right_r <= right_nxt;
      any_r   <= any_nxt;
      col_r   <= col_nxt;
      if (cfg_wr_en) begin
        scale_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_vol_r <= volume;
      out_ovf_r <= overflow;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_vol_r;
  assign out_tuser  = out_ovf_r;

  cdv_column_store #(
    .IMAGE_WIDTH (IMAGE_WIDTH),
    .COL_W       (COL_W)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .op         (op),
    .op_addr    (op_addr),
    .op_y       (pt_y),
    .stat       (stat),
    .walk_vld   (walk_vld),
    .walk_entry (walk_entry)
  );

  cdv_volume_calc #(
    .IMAGE_WIDTH    (IMAGE_WIDTH),
    .DIAMETER_LIMIT (DIAMETER_LIMIT)
  ) u_calc (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .scale      (scale_r),
    .walk_vld   (walk_vld),
    .walk_entry (walk_entry),
    .busy       (calc_busy),
    .volume     (volume),
    .overflow   (overflow)
  );

endmodule
